// File: sv/stip_pkg.sv
// Shared constants and types for the stack insert-position search unit.
package stip_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned IdxOutW  = 9;
  localparam int unsigned DepthDef = 512;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [IdxOutW-1:0]      idx_out_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic first;
  } scan_ctl_t;

  typedef struct packed {
    idx_out_t below;
    idx_out_t above;
    idx_out_t min;
    idx_out_t max;
    logic     desc;
  } scan_res_t;

endpackage

// File: sv/stip_cell.sv
// One storage cell of the element ring: loads a pushed value or takes its neighbor's value.
module stip_cell
  import stip_pkg::*;
(
  input  logic  clk_i,
  input  logic  wr_en_i,
  input  data_t wr_data_i,
  input  logic  shift_en_i,
  input  data_t nb_data_i,
  output data_t data_o
);

  data_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (wr_en_i) begin
      data_d = wr_data_i;
    end else if (shift_en_i) begin
      data_d = nb_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: sv/stip_tracker.sv
// Running min/max/predecessor/successor tracker fed one element per cycle from the ring head.
module stip_tracker
  import stip_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scan_ctl_t                  ctl_i,
  input  logic [$clog2(DEPTH)-1:0]   idx_i,
  input  data_t                      elem_i,
  input  data_t                      probe_i,
  output scan_res_t                  res_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic            has_bl_q, has_bl_d;
  logic            has_ab_q, has_ab_d;
  logic            desc_q, desc_d;
  logic [IdxW-1:0] mn_idx_q, mn_idx_d, mx_idx_q, mx_idx_d;
  logic [IdxW-1:0] bl_idx_q, bl_idx_d, ab_idx_q, ab_idx_d;
  data_t           mn_val_q, mn_val_d, mx_val_q, mx_val_d;
  data_t           bl_val_q, bl_val_d, ab_val_q, ab_val_d;
  data_t           prev_q, prev_d;

  always_comb begin
    has_bl_d = has_bl_q;
    has_ab_d = has_ab_q;
    desc_d   = desc_q;
    mn_idx_d = mn_idx_q;
    mx_idx_d = mx_idx_q;
    bl_idx_d = bl_idx_q;
    ab_idx_d = ab_idx_q;
    mn_val_d = mn_val_q;
    mx_val_d = mx_val_q;
    bl_val_d = bl_val_q;
    ab_val_d = ab_val_q;
    prev_d   = prev_q;
    if (ctl_i.clr) begin
      has_bl_d = 1'b0;
      has_ab_d = 1'b0;
      desc_d   = 1'b1;
      mn_idx_d = '0;
      mx_idx_d = '0;
      bl_idx_d = '0;
      ab_idx_d = '0;
    end else if (ctl_i.en) begin
      if (ctl_i.first || (elem_i < mn_val_q)) begin
        mn_idx_d = idx_i;
        mn_val_d = elem_i;
      end
      if (ctl_i.first || (elem_i > mx_val_q)) begin
        mx_idx_d = idx_i;
        mx_val_d = elem_i;
      end
      if ((elem_i < probe_i) && (!has_bl_q || (elem_i > bl_val_q))) begin
        bl_idx_d = idx_i;
        bl_val_d = elem_i;
        has_bl_d = 1'b1;
      end
      if ((elem_i > probe_i) && (!has_ab_q || (elem_i <= ab_val_q))) begin
        ab_idx_d = idx_i;
        ab_val_d = elem_i;
        has_ab_d = 1'b1;
      end
      if (!ctl_i.first && (prev_q < elem_i)) begin
        desc_d = 1'b0;
      end
      prev_d = elem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_bl_q <= 1'b0;
      has_ab_q <= 1'b0;
      desc_q   <= 1'b1;
    end else begin
      has_bl_q <= has_bl_d;
      has_ab_q <= has_ab_d;
      desc_q   <= desc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mn_idx_q <= mn_idx_d;
    mx_idx_q <= mx_idx_d;
    bl_idx_q <= bl_idx_d;
    ab_idx_q <= ab_idx_d;
    mn_val_q <= mn_val_d;
    mx_val_q <= mx_val_d;
    bl_val_q <= bl_val_d;
    ab_val_q <= ab_val_d;
    prev_q   <= prev_d;
  end

  assign res_o.below = IdxOutW'(has_bl_q ? bl_idx_q : mx_idx_q);
  assign res_o.above = IdxOutW'(has_ab_q ? ab_idx_q : mn_idx_q);
  assign res_o.min   = IdxOutW'(mn_idx_q);
  assign res_o.max   = IdxOutW'(mx_idx_q);
  assign res_o.desc  = desc_q;

endmodule

// File: sv/stack_insert_position_search_unit.sv
// Top level of the stack insert-position search unit: element ring, scan control, result register.
//
// Input channel (in_valid_i/in_ready_o) carries one request: cmd_i selects a load
// (push probe_or_element_i, with start_new_i emptying the stack first) or a query
// (probe_or_element_i is the probe). Pushes beyond DEPTH elements are dropped.
// Output channel (out_valid_o/out_ready_i) returns one result per query, none per load.
// A load never stalls; the next request is taken in the following cycle.
// A query rotates the element ring through all DEPTH cells, one element per cycle
// past a single tracker at the ring head; the result then goes to the output
// register once it is free. in_ready_o is low while a query scans. A finished
// result waits in the output register while out_ready_i is low; a new load or
// query may be taken meanwhile, and a later query's result holds in the tracker
// until the register frees.
// Reset empties the stack and clears the output valid flag; the element cells are
// not cleared and need no clearing pass.
module stack_insert_position_search_unit
  import stip_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cmd_i,
  input  data_t    probe_or_element_i,
  input  logic     start_new_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output idx_out_t below_index_o,
  output idx_out_t above_index_o,
  output idx_out_t min_index_o,
  output idx_out_t max_index_o,
  output logic     is_descending_o,
  output logic     is_empty_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] scan_q, scan_d;
  data_t           probe_q, probe_d;
  logic            out_valid_q, out_valid_d;
  scan_res_t       res_q, res_d;
  logic            empty_q, empty_d;

  logic            accept;
  logic            do_load;
  logic            do_query;
  logic [CntW-1:0] push_pos;
  logic            push_ok;
  logic            shift_en;
  scan_ctl_t       ctl;
  scan_res_t       trk_res;
  logic            out_free;

  data_t cell_data [DEPTH];

  assign accept   = in_valid_i && in_ready_o;
  assign do_load  = accept && (cmd_i == CmdLoad);
  assign do_query = accept && (cmd_i == CmdQuery);
  assign push_pos = start_new_i ? '0 : count_q;
  assign push_ok  = do_load && (push_pos < CntW'(DEPTH));
  assign shift_en = (state_q == StScan);
  assign out_free = !out_valid_q || out_ready_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam int unsigned Nb = (k + 1) % DEPTH;
    stip_cell u_cell (
      .clk_i      (clk_i),
      .wr_en_i    (push_ok && (push_pos == CntW'(k))),
      .wr_data_i  (probe_or_element_i),
      .shift_en_i (shift_en),
      .nb_data_i  (cell_data[Nb]),
      .data_o     (cell_data[k])
    );
  end

  assign ctl.clr   = do_query;
  assign ctl.en    = shift_en && (CntW'(scan_q) < count_q);
  assign ctl.first = (scan_q == '0);

  stip_tracker #(
    .DEPTH (DEPTH)
  ) u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .idx_i   (scan_q),
    .elem_i  (cell_data[0]),
    .probe_i (probe_q),
    .res_o   (trk_res)
  );

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    probe_d     = probe_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    empty_d     = empty_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (push_ok) begin
      count_d = push_pos + CntW'(1);
    end else if (do_load) begin
      count_d = push_pos;
    end
    case (state_q)
      StIdle: begin
        if (do_query) begin
          probe_d = probe_or_element_i;
          scan_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        scan_d = scan_q + IdxW'(1);
        if (scan_q == IdxW'(DEPTH - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          res_d       = trk_res;
          empty_d     = (count_q == '0);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    res_q   <= res_d;
    empty_q <= empty_d;
  end

  assign out_valid_o     = out_valid_q;
  assign below_index_o   = res_q.below;
  assign above_index_o   = res_q.above;
  assign min_index_o     = res_q.min;
  assign max_index_o     = res_q.max;
  assign is_descending_o = res_q.desc;
  assign is_empty_o      = empty_q;

endmodule

// File: verif/tb_stack_insert_position_search_unit.sv
// Testbench for the stack insert-position search unit: directed, overflow and random request tests.
`timescale 1ns / 100ps

module tb_stack_insert_position_search_unit;
  import stip_pkg::*;

  localparam int unsigned Depth         = DepthDef;
  localparam int unsigned TotalRequests = 1950;
  localparam data_t       MinVal        = 32'sh8000_0000;
  localparam data_t       MaxVal        = 32'sh7fff_ffff;

  typedef enum logic [1:0] {ValNarrow, ValCorner, ValWide, ValMixed} value_kind_e;

  typedef struct packed {
    idx_out_t below;
    idx_out_t above;
    idx_out_t min;
    idx_out_t max;
    logic     desc;
    logic     empty;
  } answer_t;

  logic     clk_i              = 1'b0;
  logic     rst_ni             = 1'b0;
  logic     in_valid_i         = 1'b0;
  logic     in_ready_o;
  logic     cmd_i              = CmdLoad;
  data_t    probe_or_element_i = '0;
  logic     start_new_i        = 1'b0;
  logic     out_valid_o;
  logic     out_ready_i        = 1'b0;
  idx_out_t below_index_o;
  idx_out_t above_index_o;
  idx_out_t min_index_o;
  idx_out_t max_index_o;
  logic     is_descending_o;
  logic     is_empty_o;

  data_t       stack_image [Depth];
  int unsigned stack_fill     = 0;
  answer_t     pending_answers [$];
  answer_t     oldest_answer;
  int unsigned requests_sent  = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_left     = 0;
  bit          in_calm        = 1'b0;
  bit          out_calm       = 1'b0;

  always #5 clk_i = ~clk_i;

  stack_insert_position_search_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .probe_or_element_i,
    .start_new_i,
    .out_valid_o,
    .out_ready_i,
    .below_index_o,
    .above_index_o,
    .min_index_o,
    .max_index_o,
    .is_descending_o,
    .is_empty_o
  );

  function automatic answer_t search_stack(input data_t probe);
    answer_t     a;
    int unsigned mn, mx, lo, hi;
    bit          has_lo, has_hi, desc;
    data_t       e;
    mn = 0;
    mx = 0;
    lo = 0;
    hi = 0;
    has_lo = 1'b0;
    has_hi = 1'b0;
    desc = 1'b1;
    for (int unsigned i = 0; i < stack_fill; i++) begin
      e = stack_image[i];
      if (e < stack_image[mn]) mn = i;
      if (e > stack_image[mx]) mx = i;
      if (e < probe && (!has_lo || e > stack_image[lo])) begin
        lo = i;
        has_lo = 1'b1;
      end
      if (e > probe && (!has_hi || e <= stack_image[hi])) begin
        hi = i;
        has_hi = 1'b1;
      end
      if (i + 1 < stack_fill && e < stack_image[i+1]) desc = 1'b0;
    end
    a.below = idx_out_t'(has_lo ? lo : mx);
    a.above = idx_out_t'(has_hi ? hi : mn);
    a.min   = idx_out_t'(mn);
    a.max   = idx_out_t'(mx);
    a.desc  = desc;
    a.empty = (stack_fill == 0);
    return a;
  endfunction

  function automatic int unsigned next_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic data_t pick_value(input value_kind_e kind);
    int v;
    if (kind == ValMixed) kind = value_kind_e'($urandom_range(0, 2));
    case (kind)
      ValNarrow: begin
        v = $urandom_range(0, 8);
        return data_t'(v - 4);
      end
      ValCorner: begin
        case ($urandom_range(0, 6))
          0: return MinVal;
          1: return MinVal + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return MaxVal - 1;
          default: return MaxVal;
        endcase
      end
      default: return data_t'($urandom());
    endcase
  endfunction

  // Probes often land on or next to a stored element to hit the strict compares.
  function automatic data_t pick_probe(input value_kind_e kind);
    data_t e;
    if (stack_fill != 0 && $urandom_range(0, 9) < 4) begin
      e = stack_image[$urandom_range(0, stack_fill - 1)];
      case ($urandom_range(0, 2))
        0: return e - 1;
        1: return e;
        default: return e + 1;
      endcase
    end
    return pick_value(kind);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_request(input logic cmd, input data_t value, input logic clear);
    int unsigned gap;
    gap = next_gap(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= cmd;
    probe_or_element_i <= value;
    start_new_i        <= clear;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    if (cmd == CmdQuery) begin
      pending_answers.push_back(search_stack(value));
    end else begin
      if (clear) stack_fill = 0;
      if (stack_fill < Depth) begin
        stack_image[stack_fill] = value;
        stack_fill++;
      end
    end
  endtask

  task automatic test_empty_stack();
    send_request(CmdQuery, 0, 1'b1);
    send_request(CmdLoad, MinVal, 1'b0);
    send_request(CmdQuery, MinVal, 1'b0);
    send_request(CmdQuery, 0, 1'b1);
  endtask

  task automatic test_extremes();
    send_request(CmdLoad, MaxVal, 1'b1);
    send_request(CmdLoad, MinVal, 1'b0);
    send_request(CmdLoad, MaxVal, 1'b0);
    send_request(CmdLoad, MinVal, 1'b0);
    send_request(CmdLoad, 0, 1'b0);
    send_request(CmdQuery, MaxVal, 1'b0);
    send_request(CmdQuery, MinVal, 1'b1);
    send_request(CmdQuery, 0, 1'b0);
  endtask

  task automatic test_ties_and_order();
    send_request(CmdLoad, 5, 1'b1);
    send_request(CmdLoad, 5, 1'b0);
    send_request(CmdLoad, 3, 1'b0);
    send_request(CmdLoad, -7, 1'b0);
    send_request(CmdQuery, 4, 1'b0);
    send_request(CmdQuery, -8, 1'b0);
    send_request(CmdLoad, 2, 1'b1);
    send_request(CmdLoad, 7, 1'b0);
    send_request(CmdLoad, 7, 1'b0);
    send_request(CmdLoad, 2, 1'b0);
    send_request(CmdQuery, 3, 1'b1);
    send_request(CmdLoad, -1, 1'b1);
    send_request(CmdQuery, -1, 1'b0);
  endtask

  // Fills past capacity with a non-increasing run; dropped pushes would break the order.
  task automatic test_overflow();
    data_t v;
    v = MaxVal;
    send_request(CmdLoad, v, 1'b1);
    for (int unsigned i = 1; i < Depth + 8; i++) begin
      if (i < Depth) v = v - data_t'($urandom_range(0, 1 << 21));
      else v = pick_value(ValMixed);
      send_request(CmdLoad, v, 1'b0);
      if (i == Depth / 2 || i == Depth - 1 || i == Depth + 7)
        send_request(CmdQuery, pick_probe(ValWide), 1'($urandom_range(0, 1)));
    end
    send_request(CmdQuery, MinVal, 1'b0);
    send_request(CmdQuery, MaxVal, 1'b1);
    send_request(CmdLoad, pick_value(ValMixed), 1'b1);
    send_request(CmdQuery, pick_probe(ValMixed), 1'b0);
  endtask

  task automatic test_random();
    value_kind_e kind;
    int unsigned len;
    int unsigned queries;
    bit          sorted;
    bit          clear;
    data_t       v;
    while (requests_sent < TotalRequests) begin
      in_calm = ($urandom_range(0, 5) == 0);
      kind    = value_kind_e'($urandom_range(0, 3));
      sorted  = ($urandom_range(0, 3) == 0);
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 16);
      for (int unsigned i = 0; i < len; i++) begin
        clear = (i == 0 && $urandom_range(0, 7) != 0) || ($urandom_range(0, 49) == 0);
        v = pick_value(kind);
        if (sorted && !clear && stack_fill != 0 && stack_fill < Depth &&
            v > stack_image[stack_fill-1])
          v = stack_image[stack_fill-1];
        send_request(CmdLoad, v, clear);
      end
      queries = $urandom_range(1, 4);
      repeat (queries) send_request(CmdQuery, pick_probe(kind), 1'($urandom_range(0, 1)));
    end
    in_calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_answers.size() == 0) begin
          $error("result returned with no query outstanding");
          mismatch_count++;
        end else begin
          oldest_answer = pending_answers.pop_front();
          check_field("below_index", oldest_answer.below, below_index_o);
          check_field("above_index", oldest_answer.above, above_index_o);
          check_field("min_index", oldest_answer.min, min_index_o);
          check_field("max_index", oldest_answer.max, max_index_o);
          check_field("is_descending", oldest_answer.desc, is_descending_o);
          check_field("is_empty", oldest_answer.empty, is_empty_o);
        end
      end
      if ($urandom_range(0, 299) == 0) out_calm = ~out_calm;
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  stall_left = $urandom_range(0, 2);
          [70:95]: stall_left = $urandom_range(3, 30);
          default: stall_left = $urandom_range(300, 1200);
        endcase
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_extremes();
    test_ties_and_order();
    test_overflow();
    test_random();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (Depth + 16) @(posedge clk_i);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
